[hdl/cdbc_pkg.sv]
// cdbc_pkg: shared types, register codes, reset values and helpers for the
// color difference blob centroid block. No dependencies.
package cdbc_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int CEN_W     = 11;
    localparam int OFS_W     = 12;
    localparam int SIZE_W    = 12;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [PIX_W-1:0] MARK_VALUE = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_MINUEND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTRAHEND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd6;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    localparam logic [1:0]        RST_MINUEND    = CH_RED;
    localparam logic [1:0]        RST_SUBTRAHEND = CH_GREEN;
    localparam logic [7:0]        RST_THRESHOLD  = 8'd40;
    localparam logic [7:0]        RST_BORDER     = 8'd0;
    localparam logic [SIZE_W-1:0] RST_ROW_MIN    = 12'd10;
    localparam logic [SIZE_W-1:0] RST_WIDTH      = 12'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT     = 12'd480;

    typedef struct packed {
        logic [1:0]        minuend_channel;
        logic [1:0]        subtrahend_channel;
        logic [7:0]        diff_threshold;
        logic [7:0]        border_width;
        logic [SIZE_W-1:0] row_min_count;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } cfg_t;

    // pixel part of a queue entry
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             frame_end;
        logic [OFS_W-1:0] half_w;
        logic [OFS_W-1:0] half_h;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]        out_blue;
        logic [PIX_W-1:0]        out_green;
        logic [PIX_W-1:0]        out_red;
        logic                    frame_end;
        logic                    blob_found;
        logic [CEN_W-1:0]        centroid_x;
        logic [CEN_W-1:0]        centroid_y;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
    } res_t;

    function automatic logic [PIX_W-1:0] pick_channel(
        input logic [1:0]       sel,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] r
    );
        logic [PIX_W-1:0] v;
        case (sel)
            CH_BLUE:  v = b;
            CH_GREEN: v = g;
            CH_RED:   v = r;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/cdbc_if.sv]
// cdbc_if: valid/ready channel interfaces for pixels, results and config writes.
// Depends on cdbc_pkg.
interface cdbc_pix_if import cdbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_red;

    modport source (output valid, output pixel_blue, output pixel_green,
                    output pixel_red, input ready);
    modport sink   (input valid, input pixel_blue, input pixel_green,
                    input pixel_red, output ready);
endinterface

interface cdbc_res_if import cdbc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [PIX_W-1:0]        out_blue;
    logic [PIX_W-1:0]        out_green;
    logic [PIX_W-1:0]        out_red;
    logic                    frame_end;
    logic                    blob_found;
    logic [CEN_W-1:0]        centroid_x;
    logic [CEN_W-1:0]        centroid_y;
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output frame_end, output blob_found, output centroid_x,
                    output centroid_y, output offset_x, output offset_y, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input frame_end, input blob_found, input centroid_x,
                    input centroid_y, input offset_x, input offset_y, output ready);
endinterface

interface cdbc_cfg_if import cdbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/cdbc_queue.sv]
// cdbc_queue: two-entry queue between classifier front and divider back.
// Depends on nothing.
module cdbc_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          valid
);

    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, wp_next;
    logic          rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign dout  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hdl/cdbc_front.sv]
// cdbc_front: raster position, border blanking, marking and row/frame sums.
// Depends on cdbc_pkg and cdbc_if.
module cdbc_front import cdbc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    cdbc_pix_if.sink            pix,
    input  cfg_t                cfg,
    input  logic                q_full,
    output logic                q_push,
    output pix_t                q_pix,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0]   q_tc,
    output logic [2*$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] q_tx,
    output logic [$clog2(MAX_WIDTH)+2*$clog2(MAX_HEIGHT):0] q_ty
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int CNTW = XW + 1;
    localparam int RSW  = 2 * XW;
    localparam int CTW  = XW + YW + 1;
    localparam int TXW  = 2 * XW + YW + 1;
    localparam int TYW  = XW + 2 * YW + 1;
    localparam int MXY  = (XW > YW) ? XW : YW;
    localparam int PW   = ((MXY > SIZE_W) ? MXY : SIZE_W) + 1;

    logic [XW-1:0]   col_reg, col_next;
    logic [YW-1:0]   row_reg, row_next;
    logic [CNTW-1:0] rcnt_reg, rcnt_next;
    logic [RSW-1:0]  rsum_reg, rsum_next;
    logic [CTW-1:0]  tc_reg, tc_next;
    logic [TXW-1:0]  tx_reg, tx_next;
    logic [TYW-1:0]  ty_reg, ty_next;

    logic [PW-1:0]   w, h, xe, ye, bwe;
    logic            border, mark, row_end, frame_end, qual;
    logic [PIX_W:0]  m_val, s_lim;
    logic [CNTW-1:0] cnt1;
    logic [RSW-1:0]  sum1;
    logic [CTW-1:0]  tc1;
    logic [TXW-1:0]  tx1;
    logic [TYW-1:0]  ty1;
    logic [YW+CNTW-1:0] yprod;

    assign pix.ready = !q_full;
    assign q_push    = pix.valid && !q_full;

    always_comb
    begin
        if (cfg.image_width == '0)
            w = PW'(1);
        else if (PW'(cfg.image_width) > PW'(MAX_WIDTH))
            w = PW'(MAX_WIDTH);
        else
            w = PW'(cfg.image_width);

        if (cfg.image_height == '0)
            h = PW'(1);
        else if (PW'(cfg.image_height) > PW'(MAX_HEIGHT))
            h = PW'(MAX_HEIGHT);
        else
            h = PW'(cfg.image_height);

        xe  = PW'(col_reg);
        ye  = PW'(row_reg);
        bwe = PW'(cfg.border_width);

        border = (xe < bwe) || (ye < bwe) || (xe + bwe >= w) || (ye + bwe >= h);

        m_val = {1'b0, pick_channel(cfg.minuend_channel, pix.pixel_blue,
                                    pix.pixel_green, pix.pixel_red)};
        s_lim = {1'b0, pick_channel(cfg.subtrahend_channel, pix.pixel_blue,
                                    pix.pixel_green, pix.pixel_red)}
                + {1'b0, cfg.diff_threshold};
        mark  = !border && (m_val > s_lim);

        cnt1 = rcnt_reg + CNTW'(mark);
        sum1 = rsum_reg + (mark ? RSW'(col_reg) : '0);

        row_end   = xe + PW'(1) >= w;
        frame_end = row_end && (ye + PW'(1) >= h);
        qual      = row_end && (PW'(cnt1) >= PW'(cfg.row_min_count));

        yprod = (YW+CNTW)'(row_reg) * (YW+CNTW)'(cnt1);
        tc1   = qual ? tc_reg + CTW'(cnt1) : tc_reg;
        tx1   = qual ? tx_reg + TXW'(sum1) : tx_reg;
        ty1   = qual ? ty_reg + TYW'(yprod) : ty_reg;

        q_pix.blue      = border ? '0 : pix.pixel_blue;
        q_pix.green     = border ? '0 : pix.pixel_green;
        q_pix.red       = border ? '0 : (mark ? MARK_VALUE : pix.pixel_red);
        q_pix.frame_end = frame_end;
        q_pix.half_w    = OFS_W'(w >> 1);
        q_pix.half_h    = OFS_W'(h >> 1);
        q_tc = tc1;
        q_tx = tx1;
        q_ty = ty1;

        if (row_end)
        begin
            col_next  = '0;
            rcnt_next = '0;
            rsum_next = '0;
            row_next  = frame_end ? '0 : row_reg + YW'(1);
        end
        else
        begin
            col_next  = col_reg + XW'(1);
            rcnt_next = cnt1;
            rsum_next = sum1;
            row_next  = row_reg;
        end
        tc_next = frame_end ? '0 : tc1;
        tx_next = frame_end ? '0 : tx1;
        ty_next = frame_end ? '0 : ty1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            rcnt_reg <= '0;
            rsum_reg <= '0;
            tc_reg   <= '0;
            tx_reg   <= '0;
            ty_reg   <= '0;
        end
        else if (q_push)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rcnt_reg <= rcnt_next;
            rsum_reg <= rsum_next;
            tc_reg   <= tc_next;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
        end
    end

endmodule

[hdl/cdbc_back.sv]
// cdbc_back: drains the queue, runs the centroid divisions at frame end and
// holds the result register. Depends on cdbc_pkg and cdbc_if.
module cdbc_back import cdbc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  pix_t                q_pix,
    input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0]   q_tc,
    input  logic [2*$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] q_tx,
    input  logic [$clog2(MAX_WIDTH)+2*$clog2(MAX_HEIGHT):0] q_ty,
    output logic                q_pop,
    cdbc_res_if.source          res
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CTW = XW + YW + 1;
    localparam int K   = (XW > YW) ? XW : YW;
    localparam int SW  = $clog2(K + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } st_t;

    st_t            st_reg, st_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [CTW-1:0] dvs_reg, dvs_next;
    logic [CTW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [K-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [K-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    pix_t           px_reg, px_next;
    res_t           out_reg, out_next;
    logic           ov_reg, ov_next;

    logic           out_free, load;
    logic [CTW:0]   r2x, r2y;
    logic           gex, gey;
    logic [CEN_W-1:0] cx, cy;

    assign out_free = !ov_reg || res.ready;

    assign res.valid      = ov_reg;
    assign res.out_blue   = out_reg.out_blue;
    assign res.out_green  = out_reg.out_green;
    assign res.out_red    = out_reg.out_red;
    assign res.frame_end  = out_reg.frame_end;
    assign res.blob_found = out_reg.blob_found;
    assign res.centroid_x = out_reg.centroid_x;
    assign res.centroid_y = out_reg.centroid_y;
    assign res.offset_x   = out_reg.offset_x;
    assign res.offset_y   = out_reg.offset_y;

    always_comb
    begin
        r2x = {rx_reg, dx_reg[K-1]};
        r2y = {ry_reg, dy_reg[K-1]};
        gex = r2x >= {1'b0, dvs_reg};
        gey = r2y >= {1'b0, dvs_reg};
        cx  = CEN_W'(qx_reg);
        cy  = CEN_W'(qy_reg);

        st_next   = st_reg;
        step_next = step_reg;
        dvs_next  = dvs_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        px_next   = px_reg;
        out_next  = out_reg;
        load      = 1'b0;
        q_pop     = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_pix.frame_end && (q_tc != '0))
                    begin
                        q_pop     = 1'b1;
                        px_next   = q_pix;
                        dvs_next  = q_tc;
                        rx_next   = CTW'(q_tx >> K);
                        ry_next   = CTW'(q_ty >> K);
                        dx_next   = K'(q_tx);
                        dy_next   = K'(q_ty);
                        step_next = SW'(K);
                        st_next   = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        load  = 1'b1;
                        out_next.out_blue   = q_pix.blue;
                        out_next.out_green  = q_pix.green;
                        out_next.out_red    = q_pix.red;
                        out_next.frame_end  = q_pix.frame_end;
                        out_next.blob_found = 1'b0;
                        out_next.centroid_x = '0;
                        out_next.centroid_y = '0;
                        out_next.offset_x   = '0;
                        out_next.offset_y   = '0;
                    end
                end
            end
            ST_DIV:
            begin
                rx_next   = gex ? CTW'(r2x - {1'b0, dvs_reg}) : CTW'(r2x);
                ry_next   = gey ? CTW'(r2y - {1'b0, dvs_reg}) : CTW'(r2y);
                dx_next   = dx_reg << 1;
                dy_next   = dy_reg << 1;
                qx_next   = {qx_reg[K-2:0], gex};
                qy_next   = {qy_reg[K-2:0], gey};
                step_next = step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    out_next.out_blue   = px_reg.blue;
                    out_next.out_green  = px_reg.green;
                    out_next.out_red    = px_reg.red;
                    out_next.frame_end  = 1'b1;
                    out_next.blob_found = 1'b1;
                    out_next.centroid_x = cx;
                    out_next.centroid_y = cy;
                    out_next.offset_x   = OFS_W'(cx) - px_reg.half_w;
                    out_next.offset_y   = OFS_W'(cy) - px_reg.half_h;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        ov_next = load ? 1'b1 : (res.ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvs_reg  <= dvs_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        px_reg   <= px_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

endmodule

[hdl/color_difference_blob_centroid.sv]
// color_difference_blob_centroid: top level, config registers, front, queue, back.
// Depends on cdbc_pkg, cdbc_if, cdbc_queue, cdbc_front, cdbc_back.
//
//   channel  dir  handshake        payload
//   pix      in   valid/ready      pixel_blue, pixel_green, pixel_red
//   res      out  valid/ready      out_*, frame_end, blob_found, centroid_*, offset_*
//   cfg      in   valid/ready      index (3b), data (12b); ready always high
//
// Ordinary pixels pass front, two-entry queue and result register at one per cycle
// while res is ready. A frame's last pixel with counted rows passes the back end's
// divide and finish states: one bit per cycle of the two shared-divisor divisions.
// Until full, the queue lets the front take pixels during division or output stalls.
// Reset clears positions, sums and control state; config returns to its reset values.
module color_difference_blob_centroid import cdbc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    cdbc_pix_if.sink    pix,
    cdbc_res_if.source  res,
    cdbc_cfg_if.sink    cfg
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CTW = XW + YW + 1;
    localparam int TXW = 2 * XW + YW + 1;
    localparam int TYW = XW + 2 * YW + 1;
    localparam int QW  = $bits(pix_t) + CTW + TXW + TYW;

    cfg_t           cfg_reg, cfg_next;
    logic           q_push, q_pop, q_full, q_valid;
    pix_t           f_pix, b_pix;
    logic [CTW-1:0] f_tc, b_tc;
    logic [TXW-1:0] f_tx, b_tx;
    logic [TYW-1:0] f_ty, b_ty;
    logic [QW-1:0]  q_dout;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MINUEND:    cfg_next.minuend_channel    = cfg.data[1:0];
                REG_SUBTRAHEND: cfg_next.subtrahend_channel = cfg.data[1:0];
                REG_THRESHOLD:  cfg_next.diff_threshold     = cfg.data[7:0];
                REG_BORDER:     cfg_next.border_width       = cfg.data[7:0];
                REG_ROW_MIN:    cfg_next.row_min_count      = cfg.data;
                REG_WIDTH:      cfg_next.image_width        = cfg.data;
                REG_HEIGHT:     cfg_next.image_height       = cfg.data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minuend_channel    <= RST_MINUEND;
            cfg_reg.subtrahend_channel <= RST_SUBTRAHEND;
            cfg_reg.diff_threshold     <= RST_THRESHOLD;
            cfg_reg.border_width       <= RST_BORDER;
            cfg_reg.row_min_count      <= RST_ROW_MIN;
            cfg_reg.image_width        <= RST_WIDTH;
            cfg_reg.image_height       <= RST_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cdbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_pix  (f_pix),
        .q_tc   (f_tc),
        .q_tx   (f_tx),
        .q_ty   (f_ty)
    );

    cdbc_queue #(
        .DW (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_pix, f_tc, f_tx, f_ty}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .valid (q_valid)
    );

    assign {b_pix, b_tc, b_tx, b_ty} = q_dout;

    cdbc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pix   (b_pix),
        .q_tc    (b_tc),
        .q_tx    (b_tx),
        .q_ty    (b_ty),
        .q_pop   (q_pop),
        .res     (res)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> !q_push || q_full)
        else $error("queue full state lost");

    a_found_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.blob_found) |-> res.frame_end)
        else $error("blob flagged on a pixel that does not end a frame");

    a_plain_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.blob_found) |->
            (res.centroid_x == '0) && (res.centroid_y == '0) &&
            (res.offset_x == '0) && (res.offset_y == '0))
        else $error("centroid fields set without a blob");

endmodule

[bench/color_difference_blob_centroid_tb.sv]
// Self-checking bench for color_difference_blob_centroid: a directed table, then random
// frames; typed table rows use their own expected result, the rest an in-bench predictor.
// Depends on cdbc_pkg, cdbc_if and the block's RTL.
module color_difference_blob_centroid_tb import cdbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int NUM_ROWS = 37;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic [PIX_W-1:0]     b;
        logic [PIX_W-1:0]     g;
        logic [PIX_W-1:0]     r;
        logic                 typed;
        res_t                 exp;
    } plan_row_t;

    logic clk;
    logic rst_n;

    cdbc_pix_if pix_bus ();
    cdbc_res_if res_bus ();
    cdbc_cfg_if cfg_bus ();

    color_difference_blob_centroid #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // predictor state
    cfg_t        shadow_cfg;
    logic [10:0] col_pos;
    logic [10:0] row_pos;
    logic [11:0] row_cnt;
    logic [21:0] row_sum;
    logic [22:0] tot_cnt;
    logic [33:0] tot_x;
    logic [33:0] tot_y;

    res_t pending_results[$];
    int   errors;
    int   frames_done;
    int   src_stretch;
    bit   src_calm;
    int   sink_stretch;
    bit   sink_calm;
    int   stall_left;

    plan_row_t directed_plan [NUM_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int idle_len(input bit calm);
        int p;
        p = $urandom_range(99);
        if (calm || p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(3, 1);
        return $urandom_range(50, 20);
    endfunction

    function automatic logic [PIX_W-1:0] rand_byte();
        int p;
        p = $urandom_range(99);
        if (p < 25)
            return 8'd0;
        if (p < 50)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic int channel_value(input logic [1:0] sel, input logic [PIX_W-1:0] b,
                                         input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] r);
        case (sel)
            CH_BLUE:  return int'(b);
            CH_GREEN: return int'(g);
            CH_RED:   return int'(r);
            default:  return 0;
        endcase
    endfunction

    function automatic res_t px_out(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                                    input logic [PIX_W-1:0] r, input logic fe,
                                    input logic found);
        res_t o;
        o = '0;
        o.out_blue   = b;
        o.out_green  = g;
        o.out_red    = r;
        o.frame_end  = fe;
        o.blob_found = found;
        return o;
    endfunction

    // Advances the pixel/row/frame state by one pixel and returns its result.
    function automatic res_t process_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                                           input logic [PIX_W-1:0] r);
        res_t o;
        int w, h, bw, x, y, m, s, cx, cy;
        bit row_end, fe;
        longint unsigned q;
        w  = (shadow_cfg.image_width == 0) ? 1 :
             (int'(shadow_cfg.image_width) > MAX_W) ? MAX_W : int'(shadow_cfg.image_width);
        h  = (shadow_cfg.image_height == 0) ? 1 :
             (int'(shadow_cfg.image_height) > MAX_H) ? MAX_H : int'(shadow_cfg.image_height);
        bw = int'(shadow_cfg.border_width);
        x  = int'(col_pos);
        y  = int'(row_pos);
        o  = px_out(b, g, r, 1'b0, 1'b0);

        if (x < bw || y < bw || x >= w - bw || y >= h - bw)
        begin
            o.out_blue  = '0;
            o.out_green = '0;
            o.out_red   = '0;
        end
        else
        begin
            m = channel_value(shadow_cfg.minuend_channel, b, g, r);
            s = channel_value(shadow_cfg.subtrahend_channel, b, g, r);
            if (m - s > int'(shadow_cfg.diff_threshold))
            begin
                o.out_red = MARK_VALUE;
                row_cnt   = row_cnt + 12'd1;
                row_sum   = row_sum + 22'(x);
            end
        end

        row_end = (x >= w - 1);
        fe      = row_end && (y >= h - 1);

        if (row_end)
        begin
            if (row_cnt >= shadow_cfg.row_min_count)
            begin
                tot_cnt = tot_cnt + 23'(row_cnt);
                tot_x   = tot_x + 34'(row_sum);
                tot_y   = tot_y + 34'(longint'(y) * longint'(row_cnt));
            end
            row_cnt = '0;
            row_sum = '0;
            col_pos = '0;
            row_pos = row_pos + 11'd1;
        end
        else
            col_pos = col_pos + 11'd1;

        if (fe)
        begin
            o.frame_end = 1'b1;
            if (tot_cnt != 0)
            begin
                q  = longint'(tot_x) / longint'(tot_cnt);
                cx = int'(q % 2048);
                q  = longint'(tot_y) / longint'(tot_cnt);
                cy = int'(q % 2048);
                o.blob_found = 1'b1;
                o.centroid_x = CEN_W'(cx);
                o.centroid_y = CEN_W'(cy);
                o.offset_x   = OFS_W'(cx - w / 2);
                o.offset_y   = OFS_W'(cy - h / 2);
            end
            col_pos = '0;
            row_pos = '0;
            tot_cnt = '0;
            tot_x   = '0;
            tot_y   = '0;
            frames_done++;
        end
        return o;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r, input bit typed, input res_t typed_exp);
        int gap;
        res_t predicted;
        if (src_stretch == 0)
        begin
            src_calm    = ($urandom_range(2) == 0);
            src_stretch = $urandom_range(120, 20);
        end
        src_stretch--;
        gap = idle_len(src_calm);
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_blue  <= b;
        pix_bus.pixel_green <= g;
        pix_bus.pixel_red   <= r;
        do @(posedge clk); while (!pix_bus.ready);
        predicted = process_pixel(b, g, r);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    // Sender holds off until every expected item has come back.
    task automatic drain(input int settle);
        pix_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MINUEND:    shadow_cfg.minuend_channel    = data[1:0];
            REG_SUBTRAHEND: shadow_cfg.subtrahend_channel = data[1:0];
            REG_THRESHOLD:  shadow_cfg.diff_threshold     = data[7:0];
            REG_BORDER:     shadow_cfg.border_width       = data[7:0];
            REG_ROW_MIN:    shadow_cfg.row_min_count      = data;
            REG_WIDTH:      shadow_cfg.image_width        = data;
            REG_HEIGHT:     shadow_cfg.image_height       = data;
            default:        ;
        endcase
    endtask

    task automatic check_field(input string name, input int e, input int a);
        if (e != a)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, e, a);
            errors++;
        end
    endtask

    // result side: random stalls, compare against oldest expectation
    initial
    begin
        res_t want;
        res_bus.ready = 1'b0;
        sink_stretch  = 0;
        stall_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result item with no expectation pending", $time);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_blue", int'(want.out_blue), int'(res_bus.out_blue));
                    check_field("out_green", int'(want.out_green), int'(res_bus.out_green));
                    check_field("out_red", int'(want.out_red), int'(res_bus.out_red));
                    check_field("frame_end", int'(want.frame_end), int'(res_bus.frame_end));
                    check_field("blob_found", int'(want.blob_found), int'(res_bus.blob_found));
                    check_field("centroid_x", int'(want.centroid_x), int'(res_bus.centroid_x));
                    check_field("centroid_y", int'(want.centroid_y), int'(res_bus.centroid_y));
                    check_field("offset_x", int'(want.offset_x), int'(res_bus.offset_x));
                    check_field("offset_y", int'(want.offset_y), int'(res_bus.offset_y));
                end
            end
            if (sink_stretch == 0)
            begin
                sink_calm    = ($urandom_range(2) == 0);
                sink_stretch = $urandom_range(300, 50);
            end
            sink_stretch--;
            if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                stall_left = idle_len(sink_calm);
            end
        end
    end

    initial
    begin
        int p, w_code, h_code, eff_w, target, n, random_items;
        logic [1:0] min_sel, sub_sel;
        logic [7:0] thr, bord;
        logic [11:0] row_min, junk;
        row_kind_t prev_kind;

        rst_n               = 1'b0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel_blue  = '0;
        pix_bus.pixel_green = '0;
        pix_bus.pixel_red   = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        errors              = 0;
        frames_done         = 0;
        src_stretch         = 0;

        shadow_cfg.minuend_channel    = RST_MINUEND;
        shadow_cfg.subtrahend_channel = RST_SUBTRAHEND;
        shadow_cfg.diff_threshold     = RST_THRESHOLD;
        shadow_cfg.border_width       = RST_BORDER;
        shadow_cfg.row_min_count      = RST_ROW_MIN;
        shadow_cfg.image_width        = RST_WIDTH;
        shadow_cfg.image_height       = RST_HEIGHT;
        col_pos = '0;
        row_pos = '0;
        row_cnt = '0;
        row_sum = '0;
        tot_cnt = '0;
        tot_x   = '0;
        tot_y   = '0;

        directed_plan = '{
            // reset config: red minus green above 40
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd0, 8'd255, 1'b1, px_out(0, 0, 255, 0, 0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd255, 8'd255, 8'd0, 1'b1, px_out(255, 255, 0, 0, 0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd213, 8'd254, 1'b1, px_out(0, 213, 255, 0, 0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd214, 8'd254, 1'b1, px_out(0, 214, 254, 0, 0)},
            // zero sizes act as 1x1, changed mid-frame
            '{ROW_CFG, REG_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_HEIGHT, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_THRESHOLD, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_ROW_MIN, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd0, 8'd255, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd0, 8'd255, 1'b1, px_out(0, 0, 255, 1, 1)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1, px_out(0, 0, 0, 1, 0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd7, 8'd0, 8'd200, 1'b1, px_out(7, 0, 255, 1, 1)},
            // border wider than image
            '{ROW_CFG, REG_BORDER, 12'd1, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1, px_out(0, 0, 0, 1, 0)},
            '{ROW_CFG, REG_BORDER, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            // channel code 3 reads as zero
            '{ROW_CFG, REG_SUBTRAHEND, 12'hFFF, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_MINUEND, 12'hFFE, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd9, 8'd9, 8'd1, 1'b1, px_out(9, 9, 255, 1, 1)},
            '{ROW_CFG, REG_THRESHOLD, 12'hFFF, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd1, 8'd2, 8'd255, 1'b1, px_out(1, 2, 255, 1, 0)},
            '{ROW_CFG, REG_MINUEND, 12'd3, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_SUBTRAHEND, 12'(CH_BLUE), 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_THRESHOLD, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd255, 8'd255, 1'b1, px_out(0, 255, 255, 1, 0)},
            // small 3x2 frame, green minus red
            '{ROW_CFG, REG_MINUEND, 12'(CH_GREEN), 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_SUBTRAHEND, 12'(CH_RED), 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_THRESHOLD, 12'd100, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_ROW_MIN, 12'd1, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_WIDTH, 12'd3, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_HEIGHT, 12'd2, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_CFG, REG_NONE, 12'hABC, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd255, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd200, 8'd50, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd255, 8'd255, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd180, 8'd10, 1'b0, res_t'(0)},
            '{ROW_PIX, 3'd0, 12'd0, 8'd0, 8'd250, 8'd0, 1'b0, res_t'(0)}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        prev_kind = ROW_CFG;
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                if (prev_kind == ROW_PIX)
                    drain(20);
                write_reg(directed_plan[i].idx, directed_plan[i].data);
            end
            else
                send_pixel(directed_plan[i].b, directed_plan[i].g, directed_plan[i].r,
                           directed_plan[i].typed, directed_plan[i].exp);
            prev_kind = directed_plan[i].kind;
        end

        random_items = 0;
        while (random_items < 450)
        begin
            drain(20);
            p = $urandom_range(99);
            w_code = (p < 5) ? 0 : (p < 10) ? $urandom_range(16, 9) : $urandom_range(8, 1);
            h_code = ($urandom_range(99) < 5) ? 0 : $urandom_range(5, 1);
            eff_w  = (w_code == 0) ? 1 : w_code;
            min_sel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            sub_sel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            p = $urandom_range(99);
            thr = (p < 15) ? 8'd0 : (p < 20) ? 8'd255 :
                  (p < 70) ? 8'($urandom_range(60)) : 8'($urandom_range(255));
            p = $urandom_range(99);
            bord = (p < 60) ? 8'd0 : (p < 80) ? 8'($urandom_range(2, 1)) :
                   (p < 90) ? 8'd255 : 8'($urandom_range(255));
            p = $urandom_range(99);
            row_min = (p < 20) ? 12'd0 : (p < 70) ? 12'($urandom_range(eff_w)) :
                      (p < 80) ? 12'hFFF : 12'($urandom_range(4095));
            junk = ($urandom_range(3) == 0) ? 12'($urandom) : 12'h0;

            write_reg(REG_MINUEND, (junk & 12'hFFC) | 12'(min_sel));
            write_reg(REG_SUBTRAHEND, ((junk << 1) & 12'hFFC) | 12'(sub_sel));
            write_reg(REG_THRESHOLD, (junk & 12'hF00) | 12'(thr));
            write_reg(REG_BORDER, ((junk << 2) & 12'hF00) | 12'(bord));
            write_reg(REG_ROW_MIN, row_min);
            write_reg(REG_WIDTH, 12'(w_code));
            write_reg(REG_HEIGHT, 12'(h_code));
            if ($urandom_range(9) == 0)
                write_reg(REG_NONE, 12'($urandom));

            if ($urandom_range(99) < 80)
            begin
                target = frames_done + $urandom_range(3, 1);
                while (frames_done < target)
                begin
                    send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, res_t'(0));
                    random_items++;
                    if ($urandom_range(199) == 0)
                        drain(0);
                end
            end
            else
            begin
                // broken frame: stops after a random pixel count, next settings take over
                n = $urandom_range(20, 1);
                repeat (n)
                begin
                    send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, res_t'(0));
                    random_items++;
                end
            end
        end

        while (col_pos != 0 || row_pos != 0)
            send_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, res_t'(0));

        drain(30);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
